[rtl/core/pbad_pkg.sv]
`timescale 1ns / 1ps
package pbad_pkg;

  localparam int OUT_WIDTH  = 64;
  localparam int OUT_HEIGHT = 64;
  localparam int SCALE_X    = 5;
  localparam int SCALE_Y    = 3;
  localparam int SRC_WIDTH  = 320;
  localparam int SRC_HEIGHT = 200;

  localparam int COL_W      = 9;
  localparam int ROW_W      = 8;
  localparam int CODE_W     = 8;
  localparam int PAL_AW     = 4;
  localparam int PAL_DEPTH  = 16;
  localparam int RGB_W      = 16;
  localparam int OXY_W      = 6;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int SUB_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_Y = 1'b1;

  localparam logic CMD_PIXEL     = 1'b0;
  localparam logic CMD_PAL_WRITE = 1'b1;

  localparam logic [ROW_W-1:0] BORDER_Y_RST = 8'd4;

  localparam int SUM_AW  = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
  localparam int BLOCK_N = SCALE_X * SCALE_Y;
  localparam int SR_W    = $clog2(31 * BLOCK_N + 1);
  localparam int SG_W    = $clog2(63 * BLOCK_N + 1);
  localparam int SUM_W   = 2 * SR_W + SG_W;

  localparam int DIV_K    = 16;
  localparam int RECIP_W  = DIV_K + 1;
  localparam int RECIP_X  = ((1 << DIV_K) + SCALE_X - 1) / SCALE_X;
  localparam int RECIP_Y  = ((1 << DIV_K) + SCALE_Y - 1) / SCALE_Y;
  localparam int AVG_K    = 20;
  localparam int RECIPN_W = AVG_K + 1;
  localparam int RECIP_N  = ((1 << AVG_K) + BLOCK_N - 1) / BLOCK_N;

  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [OXY_W-1:0] oxy_t;

endpackage

[rtl/core/palette_box_average_downscaler.sv]
`timescale 1ns / 1ps
// Palette box-average downscaler: takes one transfer per clock on the input channel, either a
// palette write or a source pixel, and keeps that rate as long as the result channel keeps up.
// The closing pixel of a block carries its sums to stage 4, which loads the output register.
// Per-column channel sums live in a single synchronous memory, read by stage 2 and written
// back by stage 3; the stage 3 sum is forwarded when the next pixel reads the same column, so
// neighbouring pixels of the same column run back to back. The sum memory needs no clearing
// pass: the first pixel of every block overwrites its entry. The user must write the border
// registers only while no pixel is in flight; the block itself does not enforce it.
module palette_box_average_downscaler
  import pbad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic                  in_frame_start,
  input  logic [CODE_W-1:0]     in_pixel_code,
  input  logic [PAL_AW-1:0]     in_palette_addr,
  input  logic [RGB_W-1:0]      in_palette_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rgb_t                  out_rgb565,
  output oxy_t                  out_x,
  output oxy_t                  out_y,
  output logic                  out_last
);

  localparam int PX_W = COL_W + RECIP_W;
  localparam int PY_W = ROW_W + RECIP_W;

  logic                 en;
  logic                 acc;
  logic                 pix_acc;
  logic                 pal_acc;

  logic [COL_W-1:0]     border_x_r;
  logic [ROW_W-1:0]     border_y_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic [COL_W-1:0]     col_cur;
  logic [ROW_W-1:0]     row_cur;
  logic [COL_W:0]       col_inc;
  logic [ROW_W:0]       row_inc;
  logic [COL_W-1:0]     col_nxt;
  logic [ROW_W-1:0]     row_nxt;
  logic [RGB_W-1:0]     pal_r [PAL_DEPTH];

  logic                 s1_valid_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [ROW_W-1:0]     s1_row_r;
  rgb_t                 s1_colour_r;
  logic                 s1_inwin;
  logic [COL_W-1:0]     s1_wx;
  logic [ROW_W-1:0]     s1_wy;

  logic                 s2_valid_r;
  logic [COL_W-1:0]     s2_wx_r;
  logic [ROW_W-1:0]     s2_wy_r;
  logic [PX_W-1:0]      s2_px_r;
  logic [PY_W-1:0]      s2_py_r;
  rgb_t                 s2_colour_r;
  logic [COL_W-1:0]     s2_ox;
  logic [ROW_W-1:0]     s2_oy;
  logic [COL_W-1:0]     s2_ox_mul;
  logic [ROW_W-1:0]     s2_oy_mul;
  logic [COL_W-1:0]     s2_sx_full;
  logic [ROW_W-1:0]     s2_sy_full;
  logic [SUB_W-1:0]     s2_sx;
  logic [SUB_W-1:0]     s2_sy;
  logic                 s2_ok;
  logic [SUM_AW-1:0]    s2_addr;

  logic [SUM_W-1:0]     sum_mem [OUT_WIDTH];
  logic [SUM_W-1:0]     mem_rd_r;
  logic [SUM_W-1:0]     fwd_data_r;

  logic                 s3_valid_r;
  logic [SUM_AW-1:0]    s3_addr_r;
  oxy_t                 s3_ox_r;
  oxy_t                 s3_oy_r;
  logic                 s3_first_r;
  logic                 s3_final_r;
  logic                 s3_fwd_r;
  logic [4:0]           s3_cr_r;
  logic [5:0]           s3_cg_r;
  logic [4:0]           s3_cb_r;
  logic [SUM_W-1:0]     s3_base;
  logic [SR_W-1:0]      s3_sr;
  logic [SG_W-1:0]      s3_sg;
  logic [SR_W-1:0]      s3_sb;
  logic [SUM_W-1:0]     s3_new;

  logic                 s4_valid_r;
  logic [SR_W-1:0]      s4_sr_r;
  logic [SG_W-1:0]      s4_sg_r;
  logic [SR_W-1:0]      s4_sb_r;
  oxy_t                 s4_ox_r;
  oxy_t                 s4_oy_r;
  logic                 s4_last_r;
  logic [SR_W+RECIPN_W-1:0] q_r_prod;
  logic [SG_W+RECIPN_W-1:0] q_g_prod;
  logic [SR_W+RECIPN_W-1:0] q_b_prod;

  logic                 out_valid_r;
  rgb_t                 out_rgb_r;
  oxy_t                 out_x_r;
  oxy_t                 out_y_r;
  logic                 out_last_r;

  // Hold everything only when a finished result is blocked behind a stalled output.
  assign en       = !(s4_valid_r && out_valid_r && out_stall);
  assign in_stall = !en;
  assign acc      = in_valid && en;
  assign pix_acc  = acc && (in_command == CMD_PIXEL);
  assign pal_acc  = acc && (in_command == CMD_PAL_WRITE);

  assign col_cur = in_frame_start ? '0 : col_r;
  assign row_cur = in_frame_start ? '0 : row_r;
  assign col_inc = {1'b0, col_cur} + 1'b1;
  assign row_inc = {1'b0, row_cur} + 1'b1;

  always_comb begin
    col_nxt = col_inc[COL_W-1:0];
    row_nxt = row_cur;
    if (col_inc >= (COL_W+1)'(SRC_WIDTH)) begin
      col_nxt = '0;
      row_nxt = (row_inc >= (ROW_W+1)'(SRC_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_x_r <= '0;
      border_y_r <= BORDER_Y_RST;
      col_r      <= '0;
      row_r      <= '0;
      for (int i = 0; i < PAL_DEPTH; i++) begin
        pal_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BORDER_X: border_x_r <= cfg_data;
          CFG_BORDER_Y: border_y_r <= cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (pix_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (pal_acc) begin
        pal_r[in_palette_addr] <= in_palette_value;
      end
    end
  end

  // Stage 1: window test and reciprocal products.
  assign s1_inwin = (s1_col_r >= border_x_r) && (s1_row_r >= border_y_r);
  assign s1_wx    = s1_col_r - border_x_r;
  assign s1_wy    = s1_row_r - border_y_r;

  // Stage 2: block coordinates, sub-block position, sum read.
  assign s2_ox      = s2_px_r[DIV_K +: COL_W];
  assign s2_oy      = s2_py_r[DIV_K +: ROW_W];
  assign s2_ox_mul  = s2_ox * COL_W'(SCALE_X);
  assign s2_oy_mul  = s2_oy * ROW_W'(SCALE_Y);
  assign s2_sx_full = s2_wx_r - s2_ox_mul;
  assign s2_sy_full = s2_wy_r - s2_oy_mul;
  assign s2_sx      = s2_sx_full[SUB_W-1:0];
  assign s2_sy      = s2_sy_full[SUB_W-1:0];
  assign s2_ok      = s2_valid_r && (s2_ox < COL_W'(OUT_WIDTH))
                      && (s2_oy < ROW_W'(OUT_HEIGHT));
  assign s2_addr    = s2_ox[SUM_AW-1:0];

  // Stage 3: accumulate, write back.
  assign s3_base = s3_fwd_r ? fwd_data_r : mem_rd_r;
  assign s3_sr   = s3_first_r ? SR_W'(s3_cr_r)
                              : s3_base[SUM_W-1 -: SR_W] + SR_W'(s3_cr_r);
  assign s3_sg   = s3_first_r ? SG_W'(s3_cg_r)
                              : s3_base[SR_W+SG_W-1 -: SG_W] + SG_W'(s3_cg_r);
  assign s3_sb   = s3_first_r ? SR_W'(s3_cb_r)
                              : s3_base[SR_W-1:0] + SR_W'(s3_cb_r);
  assign s3_new  = {s3_sr, s3_sg, s3_sb};

  // Stage 4: average by reciprocal.
  assign q_r_prod = (SR_W+RECIPN_W)'(s4_sr_r) * (SR_W+RECIPN_W)'(RECIP_N);
  assign q_g_prod = (SG_W+RECIPN_W)'(s4_sg_r) * (SG_W+RECIPN_W)'(RECIP_N);
  assign q_b_prod = (SR_W+RECIPN_W)'(s4_sb_r) * (SR_W+RECIPN_W)'(RECIP_N);

  always_ff @(posedge clk) begin
    if (en) begin
      mem_rd_r <= sum_mem[s2_addr];
      if (s3_valid_r) begin
        sum_mem[s3_addr_r] <= s3_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= pix_acc;
      s2_valid_r <= s1_valid_r && s1_inwin;
      s3_valid_r <= s2_ok;
      s4_valid_r <= s3_valid_r && s3_final_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col_r    <= col_cur;
      s1_row_r    <= row_cur;
      s1_colour_r <= pal_r[in_pixel_code[PAL_AW-1:0]];

      s2_wx_r     <= s1_wx;
      s2_wy_r     <= s1_wy;
      s2_px_r     <= PX_W'(s1_wx) * PX_W'(RECIP_X);
      s2_py_r     <= PY_W'(s1_wy) * PY_W'(RECIP_Y);
      s2_colour_r <= s1_colour_r;

      s3_addr_r   <= s2_addr;
      s3_ox_r     <= s2_ox[OXY_W-1:0];
      s3_oy_r     <= OXY_W'(s2_oy);
      s3_first_r  <= (s2_sx == '0) && (s2_sy == '0);
      s3_final_r  <= (s2_sx == SUB_W'(SCALE_X - 1)) && (s2_sy == SUB_W'(SCALE_Y - 1));
      s3_fwd_r    <= s3_valid_r && (s2_addr == s3_addr_r);
      s3_cr_r     <= s2_colour_r[15:11];
      s3_cg_r     <= s2_colour_r[10:5];
      s3_cb_r     <= s2_colour_r[4:0];
      fwd_data_r  <= s3_new;

      s4_sr_r     <= s3_sr;
      s4_sg_r     <= s3_sg;
      s4_sb_r     <= s3_sb;
      s4_ox_r     <= s3_ox_r;
      s4_oy_r     <= s3_oy_r;
      s4_last_r   <= (s3_ox_r == OXY_W'(OUT_WIDTH - 1))
                     && (s3_oy_r == OXY_W'(OUT_HEIGHT - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && s4_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_valid_r) begin
      out_rgb_r  <= {q_r_prod[AVG_K +: 5], q_g_prod[AVG_K +: 6], q_b_prod[AVG_K +: 5]};
      out_x_r    <= s4_ox_r;
      out_y_r    <= s4_oy_r;
      out_last_r <= s4_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rgb565 = out_rgb_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_last   = out_last_r;

endmodule

[rtl/core/pbad_checker.sv]
`timescale 1ns / 1ps
module pbad_checker
  import pbad_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input rgb_t out_rgb565,
  input oxy_t out_x,
  input oxy_t out_y,
  input logic out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rgb565) && $stable(out_x) && $stable(out_y)
                               && $stable(out_last))
    else $error("stalled result changed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_x == OXY_W'(OUT_WIDTH - 1))
                              && (out_y == OXY_W'(OUT_HEIGHT - 1)))
    else $error("last flag away from final block");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

bind palette_box_average_downscaler pbad_checker u_pbad_checker (.*);

[tb/palette_box_average_downscaler_tb.sv]
`timescale 1ns / 1ps
module palette_box_average_downscaler_tb;
  import pbad_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_PIXELS  = (SRC_WIDTH - SCALE_X) / 3;

  typedef struct packed {
    rgb_t rgb;
    oxy_t x;
    oxy_t y;
    logic last;
  } avg_pixel_t;

  typedef struct packed {
    logic              cmd;
    logic              fs;
    logic [CODE_W-1:0] code;
    logic [PAL_AW-1:0] addr;
    rgb_t              value;
    int                repeats;
    logic              known;
    avg_pixel_t        want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_stall;
  logic                  in_command       = CMD_PIXEL;
  logic                  in_frame_start   = 1'b0;
  logic [CODE_W-1:0]     in_pixel_code    = '0;
  logic [PAL_AW-1:0]     in_palette_addr  = '0;
  rgb_t                  in_palette_value = '0;
  logic                  out_valid;
  logic                  out_stall        = 1'b0;
  rgb_t                  out_rgb565;
  oxy_t                  out_x;
  oxy_t                  out_y;
  logic                  out_last;

  palette_box_average_downscaler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_frame_start   (in_frame_start),
    .in_pixel_code    (in_pixel_code),
    .in_palette_addr  (in_palette_addr),
    .in_palette_value (in_palette_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rgb565       (out_rgb565),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_last         (out_last)
  );

  // predictor state
  rgb_t pal_model [PAL_DEPTH];
  int   red_sum [OUT_WIDTH];
  int   grn_sum [OUT_WIDTH];
  int   blu_sum [OUT_WIDTH];
  int   src_col = 0;
  int   src_row = 0;
  int   win_x0  = 0;
  int   win_y0  = BORDER_Y_RST;

  avg_pixel_t pending_pixels [$];
  int         mismatches    = 0;
  int         quiet_cycles  = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  stim_row_t  directed_rows [9];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (pal_model[i]) pal_model[i] = '0;
    foreach (red_sum[i]) begin
      red_sum[i] = 0;
      grn_sum[i] = 0;
      blu_sum[i] = 0;
    end
  end

  task automatic box_average(input logic cmd, input logic fs, input logic [CODE_W-1:0] code,
                             input logic [PAL_AW-1:0] addr, input rgb_t value,
                             output bit done, output avg_pixel_t px);
    int   col, row, wx, wy, ox, oy, sx, sy;
    rgb_t colour;
    done = 1'b0;
    px   = '0;
    if (cmd == CMD_PAL_WRITE) begin
      pal_model[addr] = value;
    end else begin
      if (fs) begin
        src_col = 0;
        src_row = 0;
      end
      col = src_col;
      row = src_row;
      src_col++;
      if (src_col >= SRC_WIDTH) begin
        src_col = 0;
        src_row++;
        if (src_row >= SRC_HEIGHT) src_row = 0;
      end
      if (col >= win_x0 && row >= win_y0) begin
        wx = col - win_x0;
        wy = row - win_y0;
        ox = wx / SCALE_X;
        oy = wy / SCALE_Y;
        sx = wx % SCALE_X;
        sy = wy % SCALE_Y;
        if (ox < OUT_WIDTH && oy < OUT_HEIGHT) begin
          colour = pal_model[code[PAL_AW-1:0]];
          if (sx == 0 && sy == 0) begin
            red_sum[ox] = colour[15:11];
            grn_sum[ox] = colour[10:5];
            blu_sum[ox] = colour[4:0];
          end else begin
            red_sum[ox] += colour[15:11];
            grn_sum[ox] += colour[10:5];
            blu_sum[ox] += colour[4:0];
          end
          if (sx == SCALE_X - 1 && sy == SCALE_Y - 1) begin
            done    = 1'b1;
            px.rgb  = {5'(red_sum[ox] / BLOCK_N), 6'(grn_sum[ox] / BLOCK_N),
                       5'(blu_sum[ox] / BLOCK_N)};
            px.x    = oxy_t'(ox);
            px.y    = oxy_t'(oy);
            px.last = (ox == OUT_WIDTH - 1 && oy == OUT_HEIGHT - 1);
          end
        end
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic fs, input logic [CODE_W-1:0] code,
                           input logic [PAL_AW-1:0] addr, input rgb_t value,
                           input bit known, input avg_pixel_t known_px);
    int         gap;
    bit         taken, done;
    avg_pixel_t px;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_frame_start   <= fs;
    in_pixel_code    <= code;
    in_palette_addr  <= addr;
    in_palette_value <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    box_average(cmd, fs, code, addr, value, done, px);
    if (known) pending_pixels.push_back(known_px);
    else if (done) pending_pixels.push_back(px);
  endtask

  task automatic set_borders(input int bx, input int by);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BORDER_X;
    cfg_data  <= CFG_DATA_W'(bx);
    @(posedge clk);
    cfg_index <= CFG_BORDER_Y;
    cfg_data  <= CFG_DATA_W'(by);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_x0 = bx;
    win_y0 = by;
  endtask

  // continue the current frame with random pixels and palette writes
  task automatic run_stream(input int pixels);
    int n;
    n = 0;
    while (n < pixels) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(CMD_PAL_WRITE, 1'($urandom_range(0, 1)), CODE_W'($urandom),
                  PAL_AW'($urandom), RGB_W'($urandom), 1'b0, '0);
      end else begin
        send_item(CMD_PIXEL, 1'b0, CODE_W'($urandom), PAL_AW'($urandom), RGB_W'($urandom),
                  1'b0, '0);
        n++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(negedge clk) begin : check_results
    avg_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: rgb %h x %0d y %0d last %b",
                   out_rgb565, out_x, out_y, out_last);
      end else begin
        want = pending_pixels.pop_front();
        if (out_rgb565 !== want.rgb || out_x !== want.x || out_y !== want.y ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rgb %h x %0d y %0d last %b, %s",
                     want.rgb, want.x, want.y, want.last,
                     $sformatf("got rgb %h x %0d y %0d last %b",
                               out_rgb565, out_x, out_y, out_last));
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int k;
    directed_rows = '{
      '{CMD_PAL_WRITE, 1'b1, 8'h00, 4'd0,  16'hFFFF, 1,               1'b0, '0},
      '{CMD_PAL_WRITE, 1'b0, 8'h00, 4'd3,  16'hF800, 1,               1'b0, '0},
      '{CMD_PAL_WRITE, 1'b0, 8'h00, 4'd15, 16'h0000, 1,               1'b0, '0},
      // frame abandoned part way through the top row
      '{CMD_PIXEL,     1'b1, 8'h3F, 4'd0,  16'h0000, 150,             1'b0, '0},
      // restart: top row white, spilling into the next row
      '{CMD_PIXEL,     1'b1, 8'h50, 4'd0,  16'h0000, SRC_WIDTH + 10,  1'b0, '0},
      // palette write mid-frame: frame start ignored, position held
      '{CMD_PAL_WRITE, 1'b1, 8'hFF, 4'd7,  16'h8410, 1,               1'b0, '0},
      '{CMD_PIXEL,     1'b0, 8'h07, 4'd0,  16'h0000, SRC_WIDTH - 10,  1'b0, '0},
      '{CMD_PIXEL,     1'b0, 8'hA0, 4'd0,  16'h0000, SCALE_X - 1,     1'b0, '0},
      '{CMD_PIXEL,     1'b0, 8'hF0, 4'd0,  16'h0000, 1,               1'b1,
        '{16'hFFFF, 6'd0, 6'd0, 1'b0}}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 12;
    recv_idle_pct = 58;
    set_borders(0, 0);
    foreach (directed_rows[i]) begin
      for (k = 0; k < directed_rows[i].repeats; k++)
        send_item(directed_rows[i].cmd, directed_rows[i].fs && k == 0, directed_rows[i].code,
                  directed_rows[i].addr, directed_rows[i].value,
                  directed_rows[i].known && k == directed_rows[i].repeats - 1,
                  directed_rows[i].want);
    end
    run_stream(PHASE_PIXELS);
    send_idle_pct = 58;
    recv_idle_pct = 12;
    run_stream(PHASE_PIXELS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_stream(PHASE_PIXELS);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
